### hw/rtl/mxfp4_scaled_dot_product_defines.svh
// Assertion macros shared by the MXFP4 scaled dot product RTL.
`ifndef MXFP4_SCALED_DOT_PRODUCT_DEFINES_SVH
`define MXFP4_SCALED_DOT_PRODUCT_DEFINES_SVH

// Same-cycle implication, checked outside reset.
`define MXSDP_ASSERT_SAME(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, checked outside reset.
`define MXSDP_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

### hw/rtl/mxsdp_pkg.sv
// Shared widths, constants, types and the weight decode table.
`timescale 1ns / 1ps
`default_nettype none

package mxsdp_pkg;

    localparam int ACT_BITS   = 16;
    localparam int CODE_W     = 8;
    localparam int MAG_W      = 4;
    localparam int PROD_W     = ACT_BITS + MAG_W + 1;
    localparam int GSUM_W     = 25;
    localparam int SUM_W      = GSUM_W + 2;
    localparam int ROW_W      = 64;
    localparam int WIDE_W     = ROW_W + GSUM_W - 1;
    localparam int SHIFT_W    = 6;
    localparam int DIFF_W     = CODE_W + 2;

    localparam logic [CODE_W-1:0] SCALE_SKIP       = 8'd255;
    localparam logic [CODE_W-1:0] SCALE_BASE_RESET = 8'd127;
    localparam logic [SHIFT_W-1:0] SHIFT_LIMIT     = 6'd63;

    localparam logic signed [GSUM_W-1:0] GSUM_MAX = {1'b0, {(GSUM_W-1){1'b1}}};
    localparam logic signed [GSUM_W-1:0] GSUM_MIN = {1'b1, {(GSUM_W-1){1'b0}}};
    localparam logic signed [ROW_W-1:0]  ROW_MAX  = {1'b0, {(ROW_W-1){1'b1}}};
    localparam logic signed [ROW_W-1:0]  ROW_MIN  = {1'b1, {(ROW_W-1){1'b0}}};

    // Closed group on its way to scaling.
    typedef struct packed {
        logic signed [GSUM_W-1:0] gsum;
        logic [CODE_W-1:0]        scale;
        logic                     row_end;
        logic                     sat;
    } t_close;

    // Scaled group on its way to the row accumulator.
    typedef struct packed {
        logic signed [ROW_W-1:0] value;
        logic                    row_end;
        logic                    sat;
    } t_scaled;

    // E2M1 magnitude, doubled so that every value is an integer.
    function automatic logic [MAG_W-1:0] f_weight_mag(input logic [2:0] code);
        logic [MAG_W-1:0] mag;
        case (code)
            3'd0: mag = 4'd0;
            3'd1: mag = 4'd1;
            3'd2: mag = 4'd2;
            3'd3: mag = 4'd3;
            3'd4: mag = 4'd4;
            3'd5: mag = 4'd6;
            3'd6: mag = 4'd8;
            3'd7: mag = 4'd12;
            default: mag = 4'd0;
        endcase
        return mag;
    endfunction

endpackage

`default_nettype wire

### hw/rtl/mxsdp_group.sv
// Group stage: decodes the weight pair and accumulates the exact group sum.
`timescale 1ns / 1ps
`default_nettype none
`include "mxfp4_scaled_dot_product_defines.svh"

module mxsdp_group
    import mxsdp_pkg::*;
(
    input  wire                        i_clk,
    input  wire                        i_rst_n,
    input  wire                        i_valid,
    output logic                       o_stall,
    input  wire  [CODE_W-1:0]          i_weight_pair,
    input  wire  signed [ACT_BITS-1:0] i_act_even,
    input  wire  signed [ACT_BITS-1:0] i_act_odd,
    input  wire                        i_odd_tail,
    input  wire  [CODE_W-1:0]          i_group_scale,
    input  wire                        i_last_in_group,
    input  wire                        i_last_in_row,
    output logic                       o_close_valid,
    output t_close                     o_close,
    input  wire                        i_close_stall
);

    logic signed [GSUM_W-1:0] r_group_sum, n_group_sum;
    logic                     r_group_sat, n_group_sat;
    logic                     r_c_valid, n_c_valid;
    t_close                   r_close, n_close;

    logic                     w_accept;
    logic                     w_close;
    logic                     w_gsat;
    logic signed [PROD_W-1:0] w_prod_even;
    logic signed [PROD_W-1:0] w_prod_odd;
    logic signed [SUM_W-1:0]  w_sum;
    logic signed [GSUM_W-1:0] w_gsum;

    // Signed product of one weight nibble and its activation.
    function automatic logic signed [PROD_W-1:0] f_product(
        input logic [3:0]                code,
        input logic signed [ACT_BITS-1:0] act
    );
        logic signed [PROD_W-1:0] p;
        p = PROD_W'($signed({1'b0, f_weight_mag(code[2:0])})) * PROD_W'(act);
        return code[3] ? -p : p;
    endfunction

    // The item can enter unless the close register is full and held.
    assign o_stall  = r_c_valid && i_close_stall;
    assign w_accept = i_valid && !o_stall;
    assign w_close  = i_last_in_group || i_last_in_row;

    // Exact sum of both products, then saturation to the group width.
    always_comb begin
        w_prod_even = f_product(i_weight_pair[3:0], i_act_even);
        w_prod_odd  = i_odd_tail ? '0 : f_product(i_weight_pair[7:4], i_act_odd);
        w_sum = SUM_W'(r_group_sum) + SUM_W'(w_prod_even) + SUM_W'(w_prod_odd);
        if (w_sum > SUM_W'(GSUM_MAX)) begin
            w_gsum = GSUM_MAX;
            w_gsat = 1'b1;
        end else if (w_sum < SUM_W'(GSUM_MIN)) begin
            w_gsum = GSUM_MIN;
            w_gsat = 1'b1;
        end else begin
            w_gsum = w_sum[GSUM_W-1:0];
            w_gsat = 1'b0;
        end
    end

    // Next state: keep accumulating, or hand the closed group on and restart.
    always_comb begin
        n_group_sum = r_group_sum;
        n_group_sat = r_group_sat;
        n_close     = r_close;
        n_c_valid   = r_c_valid && i_close_stall;
        if (w_accept) begin
            if (w_close) begin
                n_group_sum     = '0;
                n_group_sat     = 1'b0;
                n_close.gsum    = w_gsum;
                n_close.scale   = i_group_scale;
                n_close.row_end = i_last_in_row;
                n_close.sat     = r_group_sat || w_gsat;
                n_c_valid       = 1'b1;
            end else begin
                n_group_sum = w_gsum;
                n_group_sat = r_group_sat || w_gsat;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_group_sum <= '0;
            r_group_sat <= 1'b0;
            r_c_valid   <= 1'b0;
        end else begin
            r_group_sum <= n_group_sum;
            r_group_sat <= n_group_sat;
            r_c_valid   <= n_c_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_close <= n_close;
    end

    assign o_close_valid = r_c_valid;
    assign o_close       = r_close;

    `MXSDP_ASSERT_NEXT(a_group_restarts, i_clk, i_rst_n, w_accept && w_close, r_group_sum == '0 && !r_group_sat, "group state not cleared after a group end")
    `MXSDP_ASSERT_SAME(a_stall_when_full, i_clk, i_rst_n, o_stall, r_c_valid, "input stalled while the close register is empty")

endmodule

`default_nettype wire

### hw/rtl/mxsdp_scale.sv
// Scale stage: holds scale_base and applies the E8M0 group scale by shifting.
`timescale 1ns / 1ps
`default_nettype none

module mxsdp_scale
    import mxsdp_pkg::*;
(
    input  wire                i_clk,
    input  wire                i_rst_n,
    input  wire                i_cfg_we,
    input  wire  [CODE_W-1:0]  i_cfg_wdata,
    input  wire                i_close_valid,
    input  wire  t_close       i_close,
    output logic               o_close_stall,
    output logic               o_scaled_valid,
    output t_scaled            o_scaled,
    input  wire                i_scaled_stall
);

    logic [CODE_W-1:0]        r_scale_base;
    logic                     r_s_valid, n_s_valid;
    t_scaled                  r_scaled, n_scaled;

    logic                     w_accept;
    logic signed [DIFF_W-1:0] w_diff;
    logic [DIFF_W-1:0]        w_rshift;
    logic [SHIFT_W-1:0]       w_ramt;
    logic signed [WIDE_W-1:0] w_wide;
    logic signed [ROW_W-1:0]  w_value;
    logic                     w_sat;

    // The user writes the scale base register only while idle; the block does not enforce this.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_scale_base <= SCALE_BASE_RESET;
        end else if (i_cfg_we) begin
            r_scale_base <= i_cfg_wdata;
        end
    end

    assign o_close_stall = r_s_valid && i_scaled_stall;
    assign w_accept      = i_close_valid && !o_close_stall;

    // Shift the group sum by the scale difference, saturating on the left; the skip code gives zero.
    always_comb begin
        w_diff   = $signed({2'b00, i_close.scale}) - $signed({2'b00, r_scale_base});
        w_rshift = DIFF_W'(-w_diff);
        w_ramt   = (w_rshift >= DIFF_W'(SHIFT_LIMIT)) ? SHIFT_LIMIT : w_rshift[SHIFT_W-1:0];
        w_wide   = WIDE_W'(i_close.gsum) <<< w_diff[SHIFT_W-1:0];
        w_value  = '0;
        w_sat    = 1'b0;
        if (i_close.scale == SCALE_SKIP) begin
            w_value = '0;
        end else if (!w_diff[DIFF_W-1]) begin
            if (i_close.gsum == '0) begin
                w_value = '0;
            end else if ((w_diff >= DIFF_W'(SHIFT_LIMIT)) ||
                         (w_wide[WIDE_W-1:ROW_W-1] != {GSUM_W{w_wide[ROW_W-1]}})) begin
                w_value = i_close.gsum[GSUM_W-1] ? ROW_MIN : ROW_MAX;
                w_sat   = 1'b1;
            end else begin
                w_value = w_wide[ROW_W-1:0];
            end
        end else begin
            w_value = ROW_W'(i_close.gsum) >>> w_ramt;
        end
    end

    // Result register of this stage.
    always_comb begin
        n_s_valid = r_s_valid && i_scaled_stall;
        n_scaled  = r_scaled;
        if (w_accept) begin
            n_s_valid        = 1'b1;
            n_scaled.value   = w_value;
            n_scaled.row_end = i_close.row_end;
            n_scaled.sat     = i_close.sat || w_sat;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s_valid <= 1'b0;
        end else begin
            r_s_valid <= n_s_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_scaled <= n_scaled;
    end

    assign o_scaled_valid = r_s_valid;
    assign o_scaled       = r_scaled;

endmodule

`default_nettype wire

### hw/rtl/mxsdp_row.sv
// Row stage: saturating 64-bit row accumulator and the result register.
`timescale 1ns / 1ps
`default_nettype none
`include "mxfp4_scaled_dot_product_defines.svh"

module mxsdp_row
    import mxsdp_pkg::*;
(
    input  wire                     i_clk,
    input  wire                     i_rst_n,
    input  wire                     i_scaled_valid,
    input  wire  t_scaled           i_scaled,
    output logic                    o_scaled_stall,
    output logic                    o_valid,
    input  wire                     i_stall,
    output logic signed [ROW_W-1:0] o_row_sum,
    output logic                    o_row_overflow
);

    logic signed [ROW_W-1:0] r_acc, n_acc;
    logic                    r_sat, n_sat;
    logic                    r_o_valid, n_o_valid;
    logic signed [ROW_W-1:0] r_o_sum, n_o_sum;
    logic                    r_o_ovf, n_o_ovf;

    logic                    w_accept;
    logic signed [ROW_W:0]   w_sum;
    logic                    w_ovf;
    logic signed [ROW_W-1:0] w_acc;

    // Only a row end needs room in the result register.
    assign o_scaled_stall = i_scaled.row_end && r_o_valid && i_stall;
    assign w_accept       = i_scaled_valid && !o_scaled_stall;

    // Saturating addition into the row accumulator.
    always_comb begin
        w_sum = (ROW_W+1)'(r_acc) + (ROW_W+1)'(i_scaled.value);
        w_ovf = w_sum[ROW_W] != w_sum[ROW_W-1];
        if (w_ovf) begin
            w_acc = w_sum[ROW_W] ? ROW_MIN : ROW_MAX;
        end else begin
            w_acc = w_sum[ROW_W-1:0];
        end
    end

    // Accumulate, or emit the row and clear the accumulator.
    always_comb begin
        n_acc     = r_acc;
        n_sat     = r_sat;
        n_o_valid = r_o_valid && i_stall;
        n_o_sum   = r_o_sum;
        n_o_ovf   = r_o_ovf;
        if (w_accept) begin
            if (i_scaled.row_end) begin
                n_acc     = '0;
                n_sat     = 1'b0;
                n_o_valid = 1'b1;
                n_o_sum   = w_acc;
                n_o_ovf   = r_sat || i_scaled.sat || w_ovf;
            end else begin
                n_acc = w_acc;
                n_sat = r_sat || i_scaled.sat || w_ovf;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_acc     <= '0;
            r_sat     <= 1'b0;
            r_o_valid <= 1'b0;
        end else begin
            r_acc     <= n_acc;
            r_sat     <= n_sat;
            r_o_valid <= n_o_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_o_sum <= n_o_sum;
        r_o_ovf <= n_o_ovf;
    end

    assign o_valid        = r_o_valid;
    assign o_row_sum      = r_o_sum;
    assign o_row_overflow = r_o_ovf;

    `MXSDP_ASSERT_NEXT(a_row_restarts, i_clk, i_rst_n, w_accept && i_scaled.row_end, r_acc == '0 && !r_sat, "row state not cleared after a row end")
    `MXSDP_ASSERT_SAME(a_no_overwrite, i_clk, i_rst_n, w_accept && i_scaled.row_end, !r_o_valid || !i_stall, "pending row result overwritten")

endmodule

`default_nettype wire

### hw/rtl/mxfp4_scaled_dot_product.sv
// Top level of the MXFP4 block-scaled dot product.
//
//  Channel  Direction  Handshake           Payload
//  input    in         i_valid / o_stall   weight_pair, act_even, act_odd, odd_tail,
//                                          group_scale, last_in_group, last_in_row
//  result   out        o_valid / i_stall   row_sum, row_overflow
//  config   in         i_cfg_we            i_cfg_wdata (scale_base)
//
// One item per cycle unless stalled; a row end passes the close, scaled and result registers.
// Throughput is set by the group sum and row accumulator loops, each closed through a single register.
// Reset is synchronous and active low; it clears both accumulators and sets scale_base to 127.
// A held result stops the pipeline only once the next row-end item reaches the row stage.
`timescale 1ns / 1ps
`default_nettype none

module mxfp4_scaled_dot_product
    import mxsdp_pkg::*;
(
    input  wire                        i_clk,
    input  wire                        i_rst_n,
    input  wire                        i_cfg_we,
    input  wire  [CODE_W-1:0]          i_cfg_wdata,
    input  wire                        i_valid,
    output logic                       o_stall,
    input  wire  [CODE_W-1:0]          i_weight_pair,
    input  wire  signed [ACT_BITS-1:0] i_act_even,
    input  wire  signed [ACT_BITS-1:0] i_act_odd,
    input  wire                        i_odd_tail,
    input  wire  [CODE_W-1:0]          i_group_scale,
    input  wire                        i_last_in_group,
    input  wire                        i_last_in_row,
    output logic                       o_valid,
    input  wire                        i_stall,
    output logic signed [ROW_W-1:0]    o_row_sum,
    output logic                       o_row_overflow
);

    logic    w_close_valid;
    t_close  w_close;
    logic    w_close_stall;
    logic    w_scaled_valid;
    t_scaled w_scaled;
    logic    w_scaled_stall;

    // Group accumulation.
    mxsdp_group u_group (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_valid        (i_valid),
        .o_stall        (o_stall),
        .i_weight_pair  (i_weight_pair),
        .i_act_even     (i_act_even),
        .i_act_odd      (i_act_odd),
        .i_odd_tail     (i_odd_tail),
        .i_group_scale  (i_group_scale),
        .i_last_in_group(i_last_in_group),
        .i_last_in_row  (i_last_in_row),
        .o_close_valid  (w_close_valid),
        .o_close        (w_close),
        .i_close_stall  (w_close_stall)
    );

    // Group scaling.
    mxsdp_scale u_scale (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cfg_we       (i_cfg_we),
        .i_cfg_wdata    (i_cfg_wdata),
        .i_close_valid  (w_close_valid),
        .i_close        (w_close),
        .o_close_stall  (w_close_stall),
        .o_scaled_valid (w_scaled_valid),
        .o_scaled       (w_scaled),
        .i_scaled_stall (w_scaled_stall)
    );

    // Row accumulation and result.
    mxsdp_row u_row (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_scaled_valid (w_scaled_valid),
        .i_scaled       (w_scaled),
        .o_scaled_stall (w_scaled_stall),
        .o_valid        (o_valid),
        .i_stall        (i_stall),
        .o_row_sum      (o_row_sum),
        .o_row_overflow (o_row_overflow)
    );

endmodule

`default_nettype wire

### dv/tb.sv
`timescale 1ns / 1ps
// Self-checking testbench for the MXFP4 block-scaled dot product: directed table, then random rows.
module tb;
    import mxsdp_pkg::*;

    localparam int RAND_ITEMS   = 950;
    localparam int N_PHASES     = 6;
    localparam int DRAIN_CYCLES = 8;
    localparam int MAX_REPORTS  = 10;
    localparam int N_DIRECTED   = 22;

    localparam logic signed [ACT_BITS-1:0] ACT_HI = {1'b0, {(ACT_BITS-1){1'b1}}};
    localparam logic signed [ACT_BITS-1:0] ACT_LO = {1'b1, {(ACT_BITS-1){1'b0}}};
    localparam logic [CODE_W-1:0] SCALE_TOP    = 8'd254;
    localparam logic [CODE_W-1:0] SCALE_BOTTOM = 8'd0;
    // Shift of 44 puts a full-scale single product just below the 64-bit limit.
    localparam logic [CODE_W-1:0] SCALE_UP44   = SCALE_BASE_RESET + 8'd44;

    // Doubled E2M1 magnitudes, indexed by the low three bits of a weight code.
    localparam longint E2M1_X2 [8] = '{0, 1, 2, 3, 4, 6, 8, 12};

    typedef struct packed {
        logic [CODE_W-1:0]          wp;
        logic signed [ACT_BITS-1:0] ae;
        logic signed [ACT_BITS-1:0] ao;
        logic                       tail;
        logic [CODE_W-1:0]          gscale;
        logic                       gend;
        logic                       rend;
        logic                       typed;
        logic signed [ROW_W-1:0]    x_sum;
        logic                       x_ovf;
    } t_stim;

    typedef struct packed {
        logic signed [ROW_W-1:0] sum;
        logic                    ovf;
    } t_row_res;

    typedef enum int {STALL_OFF, STALL_COIN, STALL_HOLD, STALL_LIGHT} t_stall_mode;

    // Directed items: zero weights, extremes, odd tail, skip code, shift limits,
    // accumulator overflow both ways, row end without group end, every weight code.
    t_stim dir_tab [N_DIRECTED] = '{
        '{8'h00, ACT_HI, ACT_HI, 1'b0, SCALE_BASE_RESET, 1'b1, 1'b1, 1'b1, 64'sd0, 1'b0},
        '{8'h77, ACT_HI, ACT_HI, 1'b0, SCALE_BASE_RESET, 1'b1, 1'b1, 1'b1, 64'sd786408, 1'b0},
        '{8'hFF, ACT_LO, ACT_LO, 1'b0, SCALE_BASE_RESET, 1'b1, 1'b1, 1'b1, 64'sd786432, 1'b0},
        '{8'h7F, ACT_HI, ACT_LO, 1'b0, SCALE_BASE_RESET, 1'b1, 1'b1, 1'b1, -64'sd786420, 1'b0},
        '{8'h71, 16'sd1000, 16'sd5000, 1'b1, SCALE_BASE_RESET, 1'b1, 1'b1, 1'b1, 64'sd1000, 1'b0},
        '{8'h11, 16'sd100, 16'sd100, 1'b0, SCALE_SKIP, 1'b1, 1'b1, 1'b1, 64'sd0, 1'b0},
        '{8'h77, ACT_HI, ACT_HI, 1'b0, SCALE_TOP, 1'b1, 1'b1, 1'b1, ROW_MAX, 1'b1},
        '{8'h0F, 16'sd1, 16'sd0, 1'b0, SCALE_BOTTOM, 1'b1, 1'b1, 1'b1, -64'sd1, 1'b0},
        '{8'h07, ACT_HI, 16'sd0, 1'b0, SCALE_UP44, 1'b1, 1'b0, 1'b0, 64'sd0, 1'b0},
        '{8'h07, ACT_HI, 16'sd0, 1'b0, SCALE_UP44, 1'b1, 1'b1, 1'b1, ROW_MAX, 1'b1},
        '{8'h0F, ACT_HI, 16'sd0, 1'b0, SCALE_UP44, 1'b1, 1'b0, 1'b0, 64'sd0, 1'b0},
        '{8'h0F, ACT_HI, 16'sd0, 1'b0, SCALE_UP44, 1'b1, 1'b1, 1'b1, ROW_MIN, 1'b1},
        '{8'h23, 16'sd300, -16'sd200, 1'b0, 8'd3, 1'b0, 1'b0, 1'b0, 64'sd0, 1'b0},
        '{8'h45, -16'sd7, 16'sd9, 1'b0, 8'd130, 1'b0, 1'b1, 1'b0, 64'sd0, 1'b0},
        '{8'h10, 16'sd5, -16'sd3, 1'b0, 8'd0, 1'b0, 1'b0, 1'b0, 64'sd0, 1'b0},
        '{8'h32, 16'sd7, 16'sd11, 1'b0, 8'd0, 1'b0, 1'b0, 1'b0, 64'sd0, 1'b0},
        '{8'h54, -16'sd13, 16'sd17, 1'b0, 8'd0, 1'b0, 1'b0, 1'b0, 64'sd0, 1'b0},
        '{8'h76, 16'sd19, -16'sd23, 1'b0, SCALE_BASE_RESET, 1'b1, 1'b0, 1'b0, 64'sd0, 1'b0},
        '{8'h98, 16'sd29, 16'sd31, 1'b0, 8'd0, 1'b0, 1'b0, 1'b0, 64'sd0, 1'b0},
        '{8'hBA, -16'sd37, 16'sd41, 1'b0, 8'd0, 1'b0, 1'b0, 1'b0, 64'sd0, 1'b0},
        '{8'hDC, 16'sd43, -16'sd47, 1'b0, 8'd0, 1'b0, 1'b0, 1'b0, 64'sd0, 1'b0},
        '{8'hFE, 16'sd53, 16'sd59, 1'b0, 8'd128, 1'b1, 1'b1, 1'b0, 64'sd0, 1'b0}
    };

    logic                       i_clk = 1'b0;
    logic                       i_rst_n = 1'b0;
    logic                       i_cfg_we = 1'b0;
    logic [CODE_W-1:0]          i_cfg_wdata = '0;
    logic                       i_valid = 1'b0;
    logic [CODE_W-1:0]          i_weight_pair = '0;
    logic signed [ACT_BITS-1:0] i_act_even = '0;
    logic signed [ACT_BITS-1:0] i_act_odd = '0;
    logic                       i_odd_tail = 1'b0;
    logic [CODE_W-1:0]          i_group_scale = '0;
    logic                       i_last_in_group = 1'b0;
    logic                       i_last_in_row = 1'b0;
    logic                       i_stall = 1'b0;
    wire                        o_stall;
    wire                        o_valid;
    wire signed [ROW_W-1:0]     o_row_sum;
    wire                        o_row_overflow;

    // Predictor state: open group sum, row total, row clip flag and unit scale code.
    longint            open_group = 0;
    longint            row_total = 0;
    bit                row_clipped = 1'b0;
    logic [CODE_W-1:0] unit_code = SCALE_BASE_RESET;

    t_row_res    pending_rows [$];
    int          err_cnt = 0;
    int unsigned burst_left = 0;
    int unsigned stall_run = 0;
    t_stall_mode stall_mode = STALL_OFF;

    mxfp4_scaled_dot_product i_dut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cfg_we        (i_cfg_we),
        .i_cfg_wdata     (i_cfg_wdata),
        .i_valid         (i_valid),
        .o_stall         (o_stall),
        .i_weight_pair   (i_weight_pair),
        .i_act_even      (i_act_even),
        .i_act_odd       (i_act_odd),
        .i_odd_tail      (i_odd_tail),
        .i_group_scale   (i_group_scale),
        .i_last_in_group (i_last_in_group),
        .i_last_in_row   (i_last_in_row),
        .o_valid         (o_valid),
        .i_stall         (i_stall),
        .o_row_sum       (o_row_sum),
        .o_row_overflow  (o_row_overflow)
    );

    initial begin
        forever #5 i_clk = ~i_clk;
    end

    // Signed weight value, doubled.
    function automatic longint e2m1_x2(input logic [3:0] code);
        return code[3] ? -E2M1_X2[code[2:0]] : E2M1_X2[code[2:0]];
    endfunction

    // Advances the dot product by one item; done is set when a row sum comes out.
    function automatic void dot_step(input t_stim it, output bit done, output t_row_res res);
        longint          s;
        longint          scaled;
        longint          wide;
        longint unsigned mag;
        longint unsigned lim;
        int              diff;
        done = 1'b0;
        res = '0;
        s = open_group + e2m1_x2(it.wp[3:0]) * longint'($signed(it.ae));
        if (!it.tail) s += e2m1_x2(it.wp[7:4]) * longint'($signed(it.ao));
        if (s > longint'(GSUM_MAX)) begin
            s = GSUM_MAX;
            row_clipped = 1'b1;
        end
        if (s < longint'(GSUM_MIN)) begin
            s = GSUM_MIN;
            row_clipped = 1'b1;
        end
        open_group = s;

        // Group close: scale relative to the unit code, then add with saturation.
        if ((it.gend || it.rend) && it.gscale != SCALE_SKIP) begin
            diff = int'(it.gscale) - int'(unit_code);
            scaled = 0;
            if (diff < 0) begin
                if (-diff >= 63) scaled = (open_group < 0) ? -1 : 0;
                else scaled = open_group >>> (-diff);
            end else if (open_group == 0) begin
                scaled = 0;
            end else if (diff >= 63) begin
                row_clipped = 1'b1;
                scaled = (open_group < 0) ? ROW_MIN : ROW_MAX;
            end else begin
                lim = 64'd1 << (63 - diff);
                mag = (open_group < 0) ? -open_group : open_group;
                if (open_group > 0 && mag >= lim) begin
                    row_clipped = 1'b1;
                    scaled = ROW_MAX;
                end else if (open_group < 0 && mag > lim) begin
                    row_clipped = 1'b1;
                    scaled = ROW_MIN;
                end else begin
                    scaled = open_group <<< diff;
                end
            end
            wide = row_total + scaled;
            if (row_total[63] == scaled[63] && wide[63] != row_total[63]) begin
                row_clipped = 1'b1;
                row_total = scaled[63] ? ROW_MIN : ROW_MAX;
            end else begin
                row_total = wide;
            end
        end
        if (it.gend || it.rend) open_group = 0;

        // Row close: emit the sum and clear everything.
        if (it.rend) begin
            done = 1'b1;
            res.sum = row_total;
            res.ovf = row_clipped;
            open_group = 0;
            row_total = 0;
            row_clipped = 1'b0;
        end
    endfunction

    function automatic logic signed [ACT_BITS-1:0] pick_act();
        case ($urandom_range(0, 9))
            0: return ACT_HI;
            1: return ACT_LO;
            2, 3, 4: return {{(ACT_BITS-8){$urandom_range(0, 1) == 1}}, 8'($urandom)};
            default: return ACT_BITS'($urandom);
        endcase
    endfunction

    task automatic flag_error(input string msg);
        err_cnt++;
        if (err_cnt <= MAX_REPORTS) $display("ERROR @%0t: %s", $time, msg);
    endtask

    // Presents one item, honoring the sender's burst pattern, and predicts on acceptance.
    task automatic drive_item(input t_stim it);
        t_row_res    res;
        bit          done;
        int unsigned gap;
        if (burst_left == 0) begin
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 10);
            if (gap != 0) begin
                i_valid <= 1'b0;
                repeat (gap) @(posedge i_clk);
            end
            burst_left = $urandom_range(1, 40);
        end
        burst_left--;
        i_valid         <= 1'b1;
        i_weight_pair   <= it.wp;
        i_act_even      <= it.ae;
        i_act_odd       <= it.ao;
        i_odd_tail      <= it.tail;
        i_group_scale   <= it.gscale;
        i_last_in_group <= it.gend;
        i_last_in_row   <= it.rend;
        do @(posedge i_clk); while (o_stall);
        dot_step(it, done, res);
        if (done) begin
            if (it.typed) begin
                res.sum = it.x_sum;
                res.ovf = it.x_ovf;
            end
            pending_rows.push_back(res);
        end
    endtask

    // Holds the sender off until every row sum is back and the pipeline is empty.
    task automatic drain_rows();
        i_valid <= 1'b0;
        burst_left = 0;
        while (pending_rows.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
    endtask

    // One random row of well-formed groups, or a short run of loose noise items.
    task automatic send_row(input logic [CODE_W-1:0] base, output int n_items);
        t_stim it;
        int    n_groups;
        int    g_len;
        int    c;
        bit    heavy;
        bit    neg;
        n_items = 0;
        if ($urandom_range(0, 9) == 0) begin
            repeat ($urandom_range(1, 6)) begin
                it        = '0;
                it.wp     = 8'($urandom);
                it.ae     = pick_act();
                it.ao     = pick_act();
                it.tail   = 1'($urandom_range(0, 1));
                it.gscale = 8'($urandom);
                it.gend   = ($urandom_range(0, 2) == 0);
                it.rend   = ($urandom_range(0, 4) == 0);
                drive_item(it);
                n_items++;
            end
        end else begin
            n_groups = $urandom_range(1, 4);
            for (int g = 0; g < n_groups; g++) begin
                // Heavy groups run full-scale products; those of 22 or more items clip the group sum.
                heavy = ($urandom_range(0, 9) == 0);
                neg   = 1'($urandom_range(0, 1));
                if (heavy) g_len = $urandom_range(20, 32);
                else if ($urandom_range(0, 6) == 0) g_len = $urandom_range(9, 32);
                else g_len = $urandom_range(1, 8);
                for (int k = 0; k < g_len; k++) begin
                    it = '0;
                    if (heavy) begin
                        it.wp = 8'h77;
                        it.ae = neg ? ACT_LO : ACT_HI;
                        it.ao = it.ae;
                    end else begin
                        it.wp   = 8'($urandom);
                        it.ae   = pick_act();
                        it.ao   = pick_act();
                        it.tail = ($urandom_range(0, 7) == 0);
                    end
                    it.gscale = 8'($urandom);
                    if (k == g_len - 1) begin
                        // Scale mostly near the unit code, sometimes skip, a random code or an extreme.
                        case ($urandom_range(0, 19))
                            0, 1: it.gscale = SCALE_SKIP;
                            2, 3, 4: it.gscale = 8'($urandom);
                            5: it.gscale = SCALE_BOTTOM;
                            6: it.gscale = SCALE_TOP;
                            default: begin
                                c = int'(base) + int'($urandom_range(0, 64)) - 24;
                                if (c < 0) c = 0;
                                if (c > int'(SCALE_TOP)) c = int'(SCALE_TOP);
                                it.gscale = 8'(c);
                            end
                        endcase
                        it.gend = (g < n_groups - 1) || ($urandom_range(0, 1) == 1);
                        it.rend = (g == n_groups - 1);
                    end
                    drive_item(it);
                    n_items++;
                end
            end
            if ($urandom_range(0, 24) == 0) drain_rows();
        end
    endtask

    // Result-side backpressure: clear runs, coin-flip runs, solid holds and light stalls.
    always @(posedge i_clk) begin
        if (stall_run == 0) begin
            stall_mode = t_stall_mode'($urandom_range(0, 3));
            stall_run  = (stall_mode == STALL_HOLD) ? $urandom_range(3, 30)
                                                    : $urandom_range(10, 80);
        end
        stall_run--;
        case (stall_mode)
            STALL_OFF: i_stall <= 1'b0;
            STALL_COIN: i_stall <= ($urandom_range(0, 1) == 1);
            STALL_HOLD: i_stall <= 1'b1;
            default: i_stall <= ($urandom_range(0, 3) == 0);
        endcase
    end

    // Compare each accepted row sum with the oldest expected one.
    always @(posedge i_clk) begin
        t_row_res want;
        if (i_rst_n && o_valid && !i_stall) begin
            if (pending_rows.size() == 0) begin
                flag_error($sformatf("unexpected row result sum=%0d ovf=%0b",
                                     o_row_sum, o_row_overflow));
            end else begin
                want = pending_rows.pop_front();
                if (o_row_sum !== want.sum || o_row_overflow !== want.ovf) begin
                    flag_error($sformatf("row mismatch: sum exp=%0d act=%0d, ovf exp=%0b act=%0b",
                                         want.sum, o_row_sum, want.ovf, o_row_overflow));
                end
            end
        end
    end

    // Main sequence: reset, directed table, then random phases at several unit scales.
    initial begin
        logic [CODE_W-1:0] phase_base [N_PHASES];
        int                sent;
        int                n;
        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        foreach (dir_tab[k]) drive_item(dir_tab[k]);

        phase_base = '{SCALE_BOTTOM, SCALE_TOP, SCALE_SKIP, SCALE_BASE_RESET, 8'd100,
                       8'($urandom_range(1, 253))};
        for (int p = 0; p < N_PHASES; p++) begin
            drain_rows();
            i_cfg_we    <= 1'b1;
            i_cfg_wdata <= phase_base[p];
            @(posedge i_clk);
            i_cfg_we    <= 1'b0;
            unit_code = phase_base[p];
            sent = 0;
            while (sent < RAND_ITEMS / N_PHASES) begin
                send_row(phase_base[p], n);
                sent += n;
            end
        end
        drain_rows();

        if (err_cnt == 0) begin
            $display("** mxfp4_scaled_dot_product: PASSED **");
        end else begin
            $display("** mxfp4_scaled_dot_product: FAILED **");
        end
        $finish;
    end

    // Watchdog: a hung handshake or a missing row sum ends here.
    initial begin
        #3_000_000;
        $display("** mxfp4_scaled_dot_product: FAILED **");
        $finish;
    end

endmodule

### mxfp4_scaled_dot_product.f
+incdir+hw/rtl
hw/rtl/mxsdp_pkg.sv
hw/rtl/mxsdp_group.sv
hw/rtl/mxsdp_scale.sv
hw/rtl/mxsdp_row.sv
hw/rtl/mxfp4_scaled_dot_product.sv
dv/tb.sv
